>>> design/btpc_pkg.sv
// Shared types, constants and pipeline stage numbers of the barometric compensation block.
package btpc_pkg;

  // Pipeline stage numbers of the back end.
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned StDiv0    = 11;
  localparam int unsigned StQuot    = StDiv0 + DivSteps + 1;
  localparam int unsigned StProd    = StQuot + 1;
  localparam int unsigned StPart    = StProd + 1;
  localparam int unsigned StCube    = StPart + 1;
  localparam int unsigned StSum     = StCube + 1;
  localparam int unsigned StLast    = StSum + 1;

  localparam logic [20:0]        PressBase = 21'd1048576;
  localparam logic signed [25:0] TfOffset  = 26'sd128000;
  localparam logic signed [63:0] DivScale  = 64'sd3125;
  localparam logic signed [63:0] XBias     = 64'sh0000_8000_0000_0000;

  typedef enum logic [1:0] {
    CfgTemp      = 2'd0,
    CfgPressLow  = 2'd1,
    CfgPressMid  = 2'd2,
    CfgPressHigh = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic [19:0]        raw_pressure;
  } front_item_t;

  // Fields that ride alongside the arithmetic through the back end.
  typedef struct packed {
    logic [19:0]        raw_pressure;
    logic signed [24:0] tf;
    logic signed [15:0] tc;
    logic               ok;
  } side_t;

endpackage

>>> design/baro_temp_press_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// Input side: a queue-like port. A conversion pair is transferred at a clock edge where
// push is high and full is low. Result side: while empty is low the oldest result is on
// out_data_o, and it is transferred at an edge where pop is high.
// One result leaves for every input transfer, in order. A new pair can be taken every
// cycle while full is low; the rate is set by the fully pipelined datapath, whose 64-step
// divider produces one quotient bit per stage.
// From an input transfer, an item passes through the front register, the middle queue,
// the 81 pipeline stages and the result queue before its result shows on the output.
// Calibration is written through cfg_we_i, cfg_idx_i and cfg_data_i, one 48-bit register
// per write. The user must change it only while no item is in flight; nothing enforces it.
// Reset clears the calibration registers and empties every queue and pipeline stage.
// When the receiver stops popping, the result queue fills, the pipeline holds its
// contents, and full rises once the middle queue and front register are occupied.
// A zero pressure divisor gives a pressure of zero with pressure_valid low.
module baro_temp_press_compensation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  btpc_pkg::in_item_t   in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output btpc_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [47:0]          cfg_data_i
);
  import btpc_pkg::*;

  logic [47:0] cal_t_q, cal_pl_q, cal_pm_q, cal_ph_q;
  cal_t        cal;
  logic        q_push, q_full, q_pop, q_empty;
  front_item_t f_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pl_q <= '0;
      cal_pm_q <= '0;
      cal_ph_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgTemp:      cal_t_q  <= cfg_data_i;
        CfgPressLow:  cal_pl_q <= cfg_data_i;
        CfgPressMid:  cal_pm_q <= cfg_data_i;
        CfgPressHigh: cal_ph_q <= cfg_data_i;
        default:      cal_t_q  <= cal_t_q;
      endcase
    end
  end

  always_comb begin
    cal.t1 = cal_t_q[15:0];
    cal.t2 = $signed(cal_t_q[31:16]);
    cal.t3 = $signed(cal_t_q[47:32]);
    cal.p1 = cal_pl_q[15:0];
    cal.p2 = $signed(cal_pl_q[31:16]);
    cal.p3 = $signed(cal_pl_q[47:32]);
    cal.p4 = $signed(cal_pm_q[15:0]);
    cal.p5 = $signed(cal_pm_q[31:16]);
    cal.p6 = $signed(cal_pm_q[47:32]);
    cal.p7 = $signed(cal_ph_q[15:0]);
    cal.p8 = $signed(cal_ph_q[31:16]);
    cal.p9 = $signed(cal_ph_q[47:32]);
  end

  btpc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .cal_i     (cal),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (f_data)
  );

  btpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (f_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  btpc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (q_data),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .cal_i      (cal),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule

>>> design/btpc_front.sv
// Front end: takes input transfers and forms the temperature differences.
module btpc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  btpc_pkg::in_item_t     in_data_i,
  input  btpc_pkg::cal_t         cal_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output btpc_pkg::front_item_t  q_data_o
);
  import btpc_pkg::*;

  logic        vld_q, vld_d;
  logic        take, move;
  front_item_t item_q, item_d;

  assign full     = vld_q && q_full_i;
  assign take     = push && !full;
  assign move     = vld_q && !q_full_i;
  assign q_push_o = move;
  assign q_data_o = item_q;
  assign vld_d    = take || (vld_q && !move);

  always_comb begin
    item_d.d1 = $signed({1'b0, in_data_i.raw_temperature[19:3]} - {1'b0, cal_i.t1, 1'b0});
    item_d.d2 = $signed({1'b0, in_data_i.raw_temperature[19:4]} - {1'b0, cal_i.t1});
    item_d.raw_pressure = in_data_i.raw_pressure;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

>>> design/btpc_queue.sv
// Two-entry queue between the front end and the back end.
module btpc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  btpc_pkg::front_item_t  data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output btpc_pkg::front_item_t  data_o,
  output logic                   empty_o
);
  import btpc_pkg::*;

  front_item_t mem_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/btpc_back.sv
// Back end: compensation pipeline with a pipelined divider and a result queue.
module btpc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  btpc_pkg::front_item_t  q_data_i,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  btpc_pkg::cal_t         cal_i,
  output logic                   empty,
  input  logic                   pop,
  output btpc_pkg::out_item_t    out_data_o
);
  import btpc_pkg::*;

  logic              adv;
  logic [StLast:1]   vld_q;
  side_t             side_q [1:StLast];
  side_t             side_d [1:StLast];

  logic signed [33:0] m1_q, m2_q;
  logic signed [22:0] v1_q;
  logic signed [37:0] m3_q;
  logic signed [24:0] tf_d;
  logic signed [25:0] a_q;
  logic signed [27:0] t5;
  logic signed [19:0] tcs;
  logic signed [15:0] tc_d;
  logic signed [51:0] aa_q;
  logic signed [41:0] ap5_q, ap2_q, ap5_6_q, ap2_6_q;
  logic signed [63:0] aap6_q, aap3_q, ap5x, ap2x, p4x, p7x;
  logic signed [63:0] b_q, x_q, xp_q, b_8_q, num0_q, num_q;
  logic [20:0]        diffp;
  logic signed [30:0] a3_q, a3_10_q;

  logic [30:0] dv_rem_q [0:DivSteps];
  logic [63:0] dv_w_q   [0:DivSteps];
  logic [30:0] dv_mb_q  [0:DivSteps];
  logic        dv_neg_q [0:DivSteps];
  logic [30:0] dv_rem_d [1:DivSteps];
  logic [63:0] dv_w_d   [1:DivSteps];

  logic signed [63:0] p_q, p_77_q, ps, ps_q, t_q, e_q, p_78_q, e_78_q;
  logic [63:0]        ll_q;
  logic [31:0]        lh_q, hl_q;
  logic signed [63:0] c_q, p_79_q, e_79_q, sum_q, r;
  out_item_t          res_d, res_q;

  out_item_t  omem_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       opush, opop;

  assign adv     = (ocnt_q != 2'd2) || pop;
  assign q_pop_o = adv && !q_empty_i;

  always_comb begin
    tf_d = v1_q + $signed(m3_q[37:14]);
    t5   = side_q[3].tf * 28'sd5 + 28'sd128;
    tcs  = $signed(t5[27:8]);
    if (tcs > 20'sd32767) begin
      tc_d = 16'sh7fff;
    end else if (tcs < -20'sd32768) begin
      tc_d = 16'sh8000;
    end else begin
      tc_d = tcs[15:0];
    end
    ap5x  = ap5_6_q;
    ap2x  = ap2_6_q;
    p4x   = cal_i.p4;
    p7x   = cal_i.p7;
    diffp = PressBase - {1'b0, side_q[8].raw_pressure};
    ps    = p_q >>> 13;
  end

  // Side fields shift along; the stages that produce them overwrite their part.
  always_comb begin
    side_d[1] = '0;
    side_d[1].raw_pressure = q_data_i.raw_pressure;
    for (int i = 2; i <= StLast; i++) begin
      side_d[i] = side_q[i-1];
    end
    side_d[3].tf         = tf_d;
    side_d[4].tc         = tc_d;
    side_d[StDiv0].ok    = (a3_10_q != '0);
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    for (int k = 1; k <= DivSteps; k++) begin
      logic [31:0] tr;
      tr = {dv_rem_q[k-1], dv_w_q[k-1][63]};
      if (tr >= {1'b0, dv_mb_q[k-1]}) begin
        dv_rem_d[k] = 31'(tr - {1'b0, dv_mb_q[k-1]});
        dv_w_d[k]   = {dv_w_q[k-1][62:0], 1'b1};
      end else begin
        dv_rem_d[k] = tr[30:0];
        dv_w_d[k]   = {dv_w_q[k-1][62:0], 1'b0};
      end
    end
  end

  always_comb begin
    r = (sum_q >>> 8) + (p7x <<< 4);
    res_d.fine_temperature  = 32'(side_q[StSum].tf);
    res_d.temperature_centi = side_q[StSum].tc;
    res_d.pressure_valid    = side_q[StSum].ok;
    if (!side_q[StSum].ok || r[63]) begin
      res_d.pressure_q24_8 = 32'd0;
    end else if (r[63:32] != 32'd0) begin
      res_d.pressure_q24_8 = 32'hffff_ffff;
    end else begin
      res_d.pressure_q24_8 = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[StLast-1:1], !q_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 1; i <= StLast; i++) begin
        side_q[i] <= side_d[i];
      end
      m1_q    <= q_data_i.d1 * cal_i.t2;
      m2_q    <= q_data_i.d2 * q_data_i.d2;
      v1_q    <= $signed(m1_q[33:11]);
      m3_q    <= $signed(m2_q[33:12]) * cal_i.t3;
      a_q     <= side_q[3].tf - TfOffset;
      aa_q    <= a_q * a_q;
      ap5_q   <= a_q * cal_i.p5;
      ap2_q   <= a_q * cal_i.p2;
      aap6_q  <= aa_q * cal_i.p6;
      aap3_q  <= aa_q * cal_i.p3;
      ap5_6_q <= ap5_q;
      ap2_6_q <= ap2_q;
      b_q     <= aap6_q + (ap5x <<< 17) + (p4x <<< 35);
      x_q     <= (aap3_q >>> 8) + (ap2x <<< 12) + XBias;
      xp_q    <= x_q * $signed({1'b0, cal_i.p1});
      b_8_q   <= b_q;
      a3_q    <= $signed(xp_q[63:33]);
      num0_q  <= $signed({12'd0, diffp, 31'd0}) - b_8_q;
      num_q   <= num0_q * DivScale;
      a3_10_q <= a3_q;

      dv_rem_q[0] <= '0;
      dv_w_q[0]   <= num_q[63] ? 64'(-num_q) : num_q;
      dv_mb_q[0]  <= a3_10_q[30] ? 31'(-a3_10_q) : a3_10_q;
      dv_neg_q[0] <= num_q[63] ^ a3_10_q[30];
      for (int k = 1; k <= DivSteps; k++) begin
        dv_rem_q[k] <= dv_rem_d[k];
        dv_w_q[k]   <= dv_w_d[k];
        dv_mb_q[k]  <= dv_mb_q[k-1];
        dv_neg_q[k] <= dv_neg_q[k-1];
      end

      p_q    <= dv_neg_q[DivSteps] ? $signed(-dv_w_q[DivSteps]) : $signed(dv_w_q[DivSteps]);
      t_q    <= cal_i.p9 * ps;
      e_q    <= cal_i.p8 * p_q;
      ps_q   <= ps;
      p_77_q <= p_q;
      ll_q   <= t_q[31:0] * ps_q[31:0];
      lh_q   <= t_q[31:0] * ps_q[63:32];
      hl_q   <= t_q[63:32] * ps_q[31:0];
      p_78_q <= p_77_q;
      e_78_q <= e_q;
      c_q    <= $signed(ll_q + {lh_q + hl_q, 32'd0}) >>> 25;
      p_79_q <= p_78_q;
      e_79_q <= e_78_q;
      sum_q  <= p_79_q + c_q + (e_79_q >>> 19);
      res_q  <= res_d;
    end
  end

  // Result queue: the pipeline keeps moving while the queue has room or a result is popped.
  assign opush      = vld_q[StLast] && adv;
  assign opop       = pop && (ocnt_q != 2'd0);
  assign empty      = (ocnt_q == 2'd0);
  assign out_data_o = omem_q[ord_q];

  always_comb begin
    case ({opush, opop})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      owr_q  <= owr_q ^ opush;
      ord_q  <= ord_q ^ opop;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      omem_q[owr_q] <= res_q;
    end
  end

endmodule
